FILE: rtl/core/madd_pkg.sv
// constants, types and arctangent table for the angle delta block
`timescale 1ns / 1ps
`default_nettype none
package madd_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int SCALE_SHIFT  = 30;
	localparam int GAIN_SHIFT   = 16;
	localparam int CFG_BITS     = 16;
	localparam int OUT_BITS     = 16;
	localparam int APB_DATA     = 32;
	localparam int APB_ADDR     = 3;

	typedef logic [CFG_BITS-1:0] cfg_word_t;

	typedef enum logic {
		REG_DEADBAND = 1'b0,
		REG_GAIN     = 1'b1
	} reg_idx_t;

	localparam cfg_word_t DEADBAND_RESET = 16'd364;
	localparam cfg_word_t GAIN_RESET     = 16'd4096;

	localparam logic signed [31:0] OUT_MAX = 32'sd32767;
	localparam logic signed [31:0] OUT_MIN = -32'sd32768;

	// atan(2^-i) with a full turn equal to 2^32
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage
`default_nettype wire

FILE: rtl/core/madd_sample_if.sv
// request channel carrying one x,y field sample
`timescale 1ns / 1ps
`default_nettype none
interface madd_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] field_x;
	logic signed [SAMPLE_BITS-1:0] field_y;

	modport source (output valid, output field_x, output field_y, input ready);
	modport sink (input valid, input field_x, input field_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/madd_result_if.sv
// result channel carrying moved flag, angle delta and level change
`timescale 1ns / 1ps
`default_nettype none
interface madd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  moved;
	logic signed [madd_pkg::OUT_BITS-1:0] angle_delta;
	logic signed [madd_pkg::OUT_BITS-1:0] level_change;

	modport source (output valid, output moved, output angle_delta, output level_change,
		input ready);
	modport sink (input valid, input moved, input angle_delta, input level_change,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/core/magnetic_angle_delta_deadband_top.sv
// registers from request accept to result valid: input, fold, CORDIC, rounding,
// decision, output; throughput: one request per cycle while result.ready is high, set
//   by the unrolled CORDIC (one vectoring iteration per stage) and the reference update
// a full stage holds only while its successor cannot advance, so bubbles are absorbed
// reset: clears pipeline valids and the reference; deadband 364, gain 4096
`timescale 1ns / 1ps
`default_nettype none
module magnetic_angle_delta_deadband_top #(
	parameter int ANGLE_BITS  = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	madd_sample_if.sink                            sample,
	madd_result_if.source                          result,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [madd_pkg::APB_ADDR-1:0]     paddr,
	input  wire logic [madd_pkg::APB_DATA-1:0]     pwdata,
	output logic      [madd_pkg::APB_DATA-1:0]     prdata,
	output logic                                   pready
);

	localparam int W     = SAMPLE_BITS + 32;
	localparam int NS    = madd_pkg::CORDIC_STEPS;
	localparam int A     = ANGLE_BITS;
	localparam int CW    = (A > madd_pkg::CFG_BITS) ? A : madd_pkg::CFG_BITS;
	localparam int PW    = A + madd_pkg::CFG_BITS + 1;
	localparam int SW    = A + madd_pkg::CFG_BITS + 2;
	localparam logic [31:0] ROUND_ADD = 32'h8000_0000 + (32'd1 << (31 - A));
	localparam logic signed [SW-1:0] SAT_HI = SW'(madd_pkg::OUT_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(madd_pkg::OUT_MIN);

	// configuration registers
	madd_pkg::cfg_word_t deadband_q, gain_q;
	madd_pkg::reg_idx_t  widx;

	assign widx   = madd_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign prdata = {16'h0, (widx == madd_pkg::REG_GAIN) ? gain_q : deadband_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= madd_pkg::DEADBAND_RESET;
			gain_q     <= madd_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				madd_pkg::REG_DEADBAND: deadband_q <= pwdata[madd_pkg::CFG_BITS-1:0];
				madd_pkg::REG_GAIN:     gain_q     <= pwdata[madd_pkg::CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and enables
	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic          en_s1, en_s2, en_s3, en_s4, en_s5;
	logic [NS-1:0] vld_sc, en_sc;

	assign en_s5 = !vld_s5 || result.ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_sc[0];
	assign en_s1 = !vld_s1 || en_s2;
	assign sample.ready = en_s1;

	// stage 1: input register
	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1;

	// stage 2: half-plane fold and scaling
	logic signed [W-1:0] xe, ye, u_pre, v_pre;
	logic signed [W-1:0] u_s2, v_s2;
	logic                neg_s2, zero_s2;

	assign xe    = W'(x_s1);
	assign ye    = W'(y_s1);
	assign u_pre = x_s1[SAMPLE_BITS-1] ? -xe : xe;
	assign v_pre = x_s1[SAMPLE_BITS-1] ? ye : -ye;

	// cordic stages
	logic signed [W-1:0] u_sc [NS];
	logic signed [W-1:0] v_sc [NS];
	logic        [31:0]  a_sc [NS];
	logic        [NS-1:0] z_sc;

	logic signed [W-1:0] iu [NS];
	logic signed [W-1:0] iv [NS];
	logic        [31:0]  ia [NS];
	logic        [NS-1:0] iz;
	logic        [NS-1:0] ivld;

	genvar gi;
	generate
		for (gi = 0; gi < NS; gi++) begin : g_cordic
			logic signed [W-1:0] du, dv;

			if (gi == 0) begin : g_first
				assign iu[gi]   = u_s2;
				assign iv[gi]   = v_s2;
				assign ia[gi]   = {neg_s2, 31'b0};
				assign iz[gi]   = zero_s2;
				assign ivld[gi] = vld_s2;
			end else begin : g_next
				assign iu[gi]   = u_sc[gi-1];
				assign iv[gi]   = v_sc[gi-1];
				assign ia[gi]   = a_sc[gi-1];
				assign iz[gi]   = z_sc[gi-1];
				assign ivld[gi] = vld_sc[gi-1];
			end

			if (gi == NS - 1) begin : g_last_en
				assign en_sc[gi] = !vld_sc[gi] || en_s3;
			end else begin : g_mid_en
				assign en_sc[gi] = !vld_sc[gi] || en_sc[gi+1];
			end

			assign du = iv[gi] >>> gi;
			assign dv = iu[gi] >>> gi;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sc[gi] <= 1'b0;
				end else if (en_sc[gi]) begin
					vld_sc[gi] <= ivld[gi];
				end
			end

			always_ff @(posedge clk) begin
				if (en_sc[gi]) begin
					z_sc[gi] <= iz[gi];
					if (iv[gi][W-1]) begin
						u_sc[gi] <= iu[gi] - du;
						v_sc[gi] <= iv[gi] + dv;
						a_sc[gi] <= ia[gi] - madd_pkg::ATAN_TURN[gi];
					end else begin
						u_sc[gi] <= iu[gi] + du;
						v_sc[gi] <= iv[gi] - dv;
						a_sc[gi] <= ia[gi] + madd_pkg::ATAN_TURN[gi];
					end
				end
			end
		end
	endgenerate

	// stage 3: half-turn offset and rounding to angle width
	logic [31:0]  round_sum;
	logic [A-1:0] ang_s3;

	assign round_sum = (z_sc[NS-1] ? 32'h0 : a_sc[NS-1]) + ROUND_ADD;

	// stage 4: wrap, deadband compare, reference update
	logic [A-1:0]        ref_q;
	logic                ref_valid_q;
	logic [A-1:0]        raw, mag;
	logic                over;
	logic                moved_s4;
	logic signed [A-1:0] delta_s4;
	logic                take_s4;

	assign raw     = ang_s3 - ref_q;
	assign mag     = raw[A-1] ? -raw : raw;
	assign over    = ref_valid_q && (CW'(mag) > CW'(deadband_q));
	assign take_s4 = en_s4 && vld_s3;

	// stage 5: gain multiply, saturation, output register
	logic signed [PW-1:0]                   prod;
	logic                                    moved_s5;
	logic signed [madd_pkg::OUT_BITS-1:0]   delta_s5, level_s5;

	assign prod = delta_s4 * $signed({1'b0, gain_q});

	function automatic logic signed [madd_pkg::OUT_BITS-1:0] sat16(
		input logic signed [SW-1:0] val
	);
		logic signed [madd_pkg::OUT_BITS-1:0] res;
		if (val > SAT_HI) begin
			res = madd_pkg::OUT_BITS'(SAT_HI);
		end else if (val < SAT_LO) begin
			res = madd_pkg::OUT_BITS'(SAT_LO);
		end else begin
			res = val[madd_pkg::OUT_BITS-1:0];
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			ref_q       <= '0;
			ref_valid_q <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= sample.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_sc[NS-1];
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (take_s4 && (!ref_valid_q || over)) begin
				ref_q       <= ang_s3;
				ref_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1 <= sample.field_x;
			y_s1 <= sample.field_y;
		end
		if (en_s2) begin
			u_s2    <= u_pre <<< madd_pkg::SCALE_SHIFT;
			v_s2    <= v_pre <<< madd_pkg::SCALE_SHIFT;
			neg_s2  <= x_s1[SAMPLE_BITS-1];
			zero_s2 <= (x_s1 == '0) && (y_s1 == '0);
		end
		if (en_s3) begin
			ang_s3 <= round_sum[31 -: A];
		end
		if (en_s4) begin
			moved_s4 <= over;
			delta_s4 <= over ? raw : '0;
		end
		if (en_s5) begin
			moved_s5 <= moved_s4;
			delta_s5 <= sat16(SW'(delta_s4));
			level_s5 <= sat16(SW'(prod >>> madd_pkg::GAIN_SHIFT));
		end
	end

	assign result.valid        = vld_s5;
	assign result.moved        = moved_s5;
	assign result.angle_delta  = delta_s5;
	assign result.level_change = level_s5;

`ifndef ASSERT_OFF
	a_still_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.moved |-> result.angle_delta == '0 && result.level_change == '0)
		else $error("unmoved result carries nonzero values");

	a_ref_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ref_valid_q |=> ref_valid_q)
		else $error("reference valid dropped");

	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		take_s4 && !ref_valid_q |=> !moved_s4)
		else $error("first sample reported movement");

	a_decide_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !en_s5 |=> vld_s4 && $stable(delta_s4) && $stable(moved_s4))
		else $error("stalled decision stage changed");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the magnetic angle delta block with deadband
`timescale 1ns / 1ps
module tb;

	localparam int ANGLE_BITS  = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int PIPE_CYCLES = madd_pkg::CORDIC_STEPS + 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT     = 599;
	localparam int HOLD_CYCLES = 250;
	localparam real TWO_PI     = 6.283185307179586;

	typedef logic signed [SAMPLE_BITS-1:0] field_t;
	typedef struct packed {
		field_t x;
		field_t y;
	} field_sample_t;
	typedef struct packed {
		logic                                 moved;
		logic signed [madd_pkg::OUT_BITS-1:0] delta;
		logic signed [madd_pkg::OUT_BITS-1:0] level;
	} move_report_t;

	localparam field_t EDGE_VALS [5] = '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};

	localparam field_sample_t DIRECTED [21] = '{
		{16'sd1000, 16'sd0}, {-16'sd1000, 16'sd0}, {16'sd0, 16'sd0},
		{16'sh7FFF, 16'sh7FFF}, {16'sh8000, 16'sh8000}, {16'sh8000, 16'sh7FFF},
		{16'sh7FFF, 16'sh8000}, {16'sd0, 16'sh8000}, {16'sd0, 16'sh7FFF},
		{16'sh8000, 16'sd0}, {16'sh7FFF, 16'sd0}, {-16'sd1, 16'sd0},
		{16'sd0, -16'sd1}, {16'sd1, 16'sd1}, {-16'sd1, -16'sd1},
		{-16'sd1, -16'sd1}, {16'sd10000, 16'sd0}, {16'sd10000, 16'sd50},
		{16'sd10000, 16'sd600}, {16'sh5555, 16'shAAAA}, {16'shAAAA, 16'sh5555}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [madd_pkg::APB_ADDR-1:0] paddr;
	logic [madd_pkg::APB_DATA-1:0] pwdata;
	logic [madd_pkg::APB_DATA-1:0] prdata;
	logic                          pready;

	madd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
	madd_result_if res ();

	magnetic_angle_delta_deadband_top #(
		.ANGLE_BITS (ANGLE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	madd_pkg::cfg_word_t   cfg_deadband = madd_pkg::DEADBAND_RESET;
	madd_pkg::cfg_word_t   cfg_gain     = madd_pkg::GAIN_RESET;
	logic [ANGLE_BITS-1:0] ref_angle    = '0;
	logic                  ref_valid    = 1'b0;

	field_sample_t pending_samples [$];
	move_report_t  expected_reports [$];
	move_report_t  want;
	field_sample_t last_sample = '0;
	real           rot_theta   = 0.0;
	bit            gaps_on     = 1'b1;
	int            n_queued    = 0;
	int            n_checked   = 0;
	int            n_errors    = 0;
	int            cycle_count = 0;
	int            gap_left    = 0;
	int            hold_left   = 0;
	int            stall_left  = 0;
	logic          hold_start;

	assign hold_start = res.valid && res.ready && (n_checked == HOLD_AT);

	function automatic logic [ANGLE_BITS-1:0] sample_angle(field_t fx, field_t fy);
		longint      u, v, du, dv;
		logic [31:0] acc, rounded;
		int          i;
		u = fx;
		v = -longint'(fy);
		acc = '0;
		if (u != 0 || v != 0) begin
			if (u < 0) begin
				u = -u;
				v = -v;
				acc = 32'h8000_0000;
			end
			u = u * (longint'(1) << madd_pkg::SCALE_SHIFT);
			v = v * (longint'(1) << madd_pkg::SCALE_SHIFT);
			for (i = 0; i < madd_pkg::CORDIC_STEPS; i++) begin
				du = v >>> i;
				dv = u >>> i;
				if (v < 0) begin
					u = u - du;
					v = v + dv;
					acc = acc - madd_pkg::ATAN_TURN[i];
				end else begin
					u = u + du;
					v = v - dv;
					acc = acc + madd_pkg::ATAN_TURN[i];
				end
			end
		end
		rounded = acc + 32'h8000_0000 + (32'd1 << (31 - ANGLE_BITS));
		return rounded[31 -: ANGLE_BITS];
	endfunction

	function automatic logic [madd_pkg::OUT_BITS-1:0] clamp_out(longint a);
		if (a > madd_pkg::OUT_MAX)
			return madd_pkg::OUT_MAX[madd_pkg::OUT_BITS-1:0];
		if (a < madd_pkg::OUT_MIN)
			return madd_pkg::OUT_MIN[madd_pkg::OUT_BITS-1:0];
		return a[madd_pkg::OUT_BITS-1:0];
	endfunction

	// updates the reference and returns the report for one sample
	function automatic move_report_t predict_report(field_t fx, field_t fy);
		logic [ANGLE_BITS-1:0] ang, diff;
		longint                delta, mag, lvl, db, g;
		move_report_t          rep;
		ang = sample_angle(fx, fy);
		rep = '0;
		db = cfg_deadband;
		g = cfg_gain;
		if (!ref_valid) begin
			ref_angle = ang;
			ref_valid = 1'b1;
		end else begin
			diff = ang - ref_angle;
			delta = $signed(diff);
			mag = (delta < 0) ? -delta : delta;
			if (mag > db) begin
				lvl = (delta * g) >>> madd_pkg::GAIN_SHIFT;
				ref_angle = ang;
				rep.moved = 1'b1;
				rep.delta = clamp_out(delta);
				rep.level = clamp_out(lvl);
			end
		end
		return rep;
	endfunction

	// mostly a turning magnet, the rest raw noise, edge values and repeats
	function automatic field_sample_t next_sample();
		field_sample_t s;
		int            pick, span;
		real           r, step;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			span = (cfg_deadband > 3000) ? 3000 : int'(cfg_deadband);
			span = 2 * span + 40;
			if ($urandom_range(0, 19) == 0)
				step = real'($urandom_range(0, 65535));
			else
				step = real'($urandom_range(0, 2 * span)) - real'(span);
			rot_theta = rot_theta + step * TWO_PI / 65536.0;
			if ($urandom_range(0, 3) == 0)
				r = real'($urandom_range(1, 60));
			else
				r = real'($urandom_range(1000, 32767));
			s.x = field_t'($rtoi(r * $cos(rot_theta)));
			s.y = field_t'($rtoi(r * $sin(rot_theta)));
		end else if (pick < 90) begin
			s.x = field_t'($urandom);
			s.y = field_t'($urandom);
		end else if (pick < 95) begin
			s.x = EDGE_VALS[$urandom_range(0, 4)];
			s.y = EDGE_VALS[$urandom_range(0, 4)];
		end else begin
			s = last_sample;
		end
		last_sample = s;
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		n_errors++;
	endtask

	task automatic queue_sample(input field_sample_t s);
		pending_samples.push_back(s);
		n_queued++;
	endtask

	task automatic reg_write(input madd_pkg::reg_idx_t idx,
		input logic [madd_pkg::APB_DATA-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			madd_pkg::REG_DEADBAND: cfg_deadband = data[madd_pkg::CFG_BITS-1:0];
			madd_pkg::REG_GAIN:     cfg_gain = data[madd_pkg::CFG_BITS-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (n_checked != n_queued)
			@(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [madd_pkg::APB_DATA-1:0] db,
		input logic [madd_pkg::APB_DATA-1:0] g, input int n, input bit gaps);
		reg_write(madd_pkg::REG_DEADBAND, db);
		reg_write(madd_pkg::REG_GAIN, g);
		gaps_on = gaps;
		repeat (n) queue_sample(next_sample());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (smp.valid && smp.ready)
				expected_reports.push_back(predict_report(smp.field_x, smp.field_y));
			if (!smp.valid || smp.ready) begin
				if (gap_left != 0) begin
					smp.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (gaps_on && $urandom_range(0, 11) == 0) begin
					smp.valid <= 1'b0;
					gap_left <= $urandom_range(0, 7);
				end else if (pending_samples.size() != 0) begin
					smp.valid <= 1'b1;
					smp.field_x <= pending_samples[0].x;
					smp.field_y <= pending_samples[0].y;
					void'(pending_samples.pop_front());
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the pipeline fills and stalls requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res.valid && res.ready) begin
				n_checked <= n_checked + 1;
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf(
						"result with no request pending: moved=%0b delta=%0d level=%0d",
						res.moved, res.angle_delta, res.level_change));
				end else begin
					want = expected_reports.pop_front();
					if (res.moved !== want.moved)
						report_mismatch($sformatf("moved %b, want %b", res.moved, want.moved));
					if (res.angle_delta !== want.delta)
						report_mismatch($sformatf("angle_delta %0d, want %0d",
							res.angle_delta, want.delta));
					if (res.level_change !== want.level)
						report_mismatch($sformatf("level_change %0d, want %0d",
							res.level_change, want.level));
				end
			end
			if (hold_start || hold_left != 0) begin
				res.ready <= 1'b0;
			end else if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				res.ready <= 1'b0;
				stall_left <= $urandom_range(0, 7);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.field_x = '0;
		smp.field_y = '0;
		res.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			queue_sample(DIRECTED[i]);
		repeat (230) queue_sample(next_sample());
		drain();

		run_phase(32'd0, 32'hFFFF, 265, 1'b1);
		run_phase(32'd32768, 32'd0, 265, 1'b1);
		run_phase(32'hFFFF, 32'd1, 250, 1'b1);
		run_phase($urandom_range(0, 2000), $urandom_range(0, 65535), 265, 1'b1);
		run_phase(32'd1, 32'h8000, 265, 1'b1);
		run_phase($urandom_range(0, 1000), $urandom_range(1, 65535), 265, 1'b0);

		if (n_errors == 0 && expected_reports.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/madd_pkg.sv
rtl/core/madd_sample_if.sv
rtl/core/madd_result_if.sv
rtl/core/magnetic_angle_delta_deadband_top.sv
tb/tb.sv
